@@ hdl/blr_pkg.sv @@
// Shared types and constants for the line rasterizer.
// Holds the coordinate widths, item operation codes, register indexes and the
// line setup record passed from the setup logic to the top level.
package blr_pkg;

  // Coordinate and derived widths.
  localparam int COORD_BITS = 11;
  localparam int SPAN_BITS  = COORD_BITS + 1;
  localparam int ERR_BITS   = COORD_BITS + 3;
  localparam int COLOR_BITS = 16;
  localparam int SIZE_BITS  = 10;
  localparam int CMP_BITS   = (COORD_BITS > SIZE_BITS + 1) ? COORD_BITS : SIZE_BITS + 1;

  // Configuration port.
  localparam int CFG_INDEX_BITS = 2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SCREEN_WIDTH  = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] REG_SCREEN_HEIGHT = CFG_INDEX_BITS'(1);
  localparam logic [SIZE_BITS-1:0] RESET_SCREEN_WIDTH  = SIZE_BITS'(128);
  localparam logic [SIZE_BITS-1:0] RESET_SCREEN_HEIGHT = SIZE_BITS'(96);

  // Operation carried by an input item.
  typedef enum logic [0:0] {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } op_t;

  // Everything a start item loads into the stepping state.
  typedef struct packed {
    logic                         steep;
    logic                         minor_neg;
    logic signed [COORD_BITS-1:0] cur_x;
    logic signed [COORD_BITS-1:0] cur_y;
    logic signed [COORD_BITS-1:0] major_end;
    logic signed [ERR_BITS-1:0]   error_term;
    logic [SPAN_BITS-1:0]         twice_major;
    logic [SPAN_BITS-1:0]         twice_minor;
  } line_setup_t;

endpackage

@@ hdl/blr_setup.sv @@
// Line setup logic for the rasterizer: picks the major axis, orders the
// endpoints and builds the initial error term. Depends on blr_pkg.
module blr_setup (
  input  logic signed [blr_pkg::COORD_BITS-1:0] x_start,
  input  logic signed [blr_pkg::COORD_BITS-1:0] y_start,
  input  logic signed [blr_pkg::COORD_BITS-1:0] x_end,
  input  logic signed [blr_pkg::COORD_BITS-1:0] y_end,
  output blr_pkg::line_setup_t                  setup
);
  import blr_pkg::*;

  logic signed [SPAN_BITS-1:0] dx;
  logic signed [SPAN_BITS-1:0] dy;
  logic [COORD_BITS-1:0]       abs_dx;
  logic [COORD_BITS-1:0]       abs_dy;
  logic                        steep;
  logic                        swap;
  logic signed [COORD_BITS-1:0] x0, y0, x1, y1;
  logic [COORD_BITS-1:0]       major;
  logic [COORD_BITS-1:0]       minor;

  // Spans along both axes; the magnitude always fits the coordinate width.
  assign dx = SPAN_BITS'(x_end) - SPAN_BITS'(x_start);
  assign dy = SPAN_BITS'(y_end) - SPAN_BITS'(y_start);
  assign abs_dx = dx[SPAN_BITS-1] ? COORD_BITS'(-dx) : COORD_BITS'(dx);
  assign abs_dy = dy[SPAN_BITS-1] ? COORD_BITS'(-dy) : COORD_BITS'(dy);

  // Ties go steep, which also covers vertical lines and single points.
  assign steep = !(abs_dy < abs_dx);
  assign swap  = steep ? (y_start > y_end) : (x_start > x_end);

  // Order the endpoints so that the major coordinate increases.
  assign x0 = swap ? x_end   : x_start;
  assign y0 = swap ? y_end   : y_start;
  assign x1 = swap ? x_start : x_end;
  assign y1 = swap ? y_start : y_end;

  assign major = steep ? abs_dy : abs_dx;
  assign minor = steep ? abs_dx : abs_dy;

  always_comb begin
    setup.steep       = steep;
    setup.minor_neg   = steep ? (x1 < x0) : (y1 < y0);
    setup.cur_x       = x0;
    setup.cur_y       = y0;
    setup.major_end   = steep ? y1 : x1;
    setup.twice_major = {major, 1'b0};
    setup.twice_minor = {minor, 1'b0};
    setup.error_term  = $signed({2'b00, minor, 1'b0}) - $signed({3'b000, major});
  end

endmodule

@@ hdl/bresenham_line_rasterizer.sv @@
// Top level of the Bresenham line rasterizer.
// Holds the input register, line state, screen size registers and result
// register; uses blr_pkg and blr_setup.
//
// A start item loads two endpoints and a color and produces no result; each
// following step item produces one point of the line in order of increasing
// major coordinate, with a clipping flag and a last flag on the final point.
// The block takes one item per clock while the input side does not stall: an
// item is captured in an input register and handled there by one setup or
// one error-term update, and its result is written to the output register.
// A step while no line is active produces nothing, and a start replaces any
// line still in progress.
// The input side stalls only while a result waits, stalled, in the output
// register and the item in the input register would produce another one.
// Screen size registers are written through the configuration port, which is
// always ready; write them only while no item is in flight.
module bresenham_line_rasterizer (
  input  logic                                  clk,
  input  logic                                  rst,
  // Configuration port.
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [blr_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [blr_pkg::SIZE_BITS-1:0]         cfg_data,
  // Input item channel.
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  operation,
  input  logic signed [blr_pkg::COORD_BITS-1:0] x_start,
  input  logic signed [blr_pkg::COORD_BITS-1:0] y_start,
  input  logic signed [blr_pkg::COORD_BITS-1:0] x_end,
  input  logic signed [blr_pkg::COORD_BITS-1:0] y_end,
  input  logic [blr_pkg::COLOR_BITS-1:0]        line_color,
  // Result item channel.
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [blr_pkg::COORD_BITS-1:0] pixel_x,
  output logic signed [blr_pkg::COORD_BITS-1:0] pixel_y,
  output logic [blr_pkg::COLOR_BITS-1:0]        pixel_color,
  output logic                                  on_screen,
  output logic                                  last
);
  import blr_pkg::*;

  // Screen size registers.
  logic [SIZE_BITS-1:0] visible_cols;
  logic [SIZE_BITS-1:0] visible_rows;

  // Input register.
  logic                         s1_valid;
  op_t                          s1_op;
  logic signed [COORD_BITS-1:0] s1_x_start;
  logic signed [COORD_BITS-1:0] s1_y_start;
  logic signed [COORD_BITS-1:0] s1_x_end;
  logic signed [COORD_BITS-1:0] s1_y_end;
  logic [COLOR_BITS-1:0]        s1_color;

  // Line state.
  logic                         busy;
  logic                         steep;
  logic                         minor_neg;
  logic signed [COORD_BITS-1:0] cur_x;
  logic signed [COORD_BITS-1:0] cur_y;
  logic signed [COORD_BITS-1:0] major_end;
  logic signed [ERR_BITS-1:0]   error_term;
  logic [SPAN_BITS-1:0]         twice_major;
  logic [SPAN_BITS-1:0]         twice_minor;
  logic [COLOR_BITS-1:0]        held_color;

  line_setup_t                  setup;
  logic                         is_start;
  logic                         emits;
  logic                         process;
  logic                         in_accept;
  logic                         is_last;
  logic                         visible;
  logic                         err_pos;
  logic signed [COORD_BITS-1:0] minor_step;
  logic signed [ERR_BITS-1:0]   error_term_next;
  logic signed [COORD_BITS-1:0] cur_x_next;
  logic signed [COORD_BITS-1:0] cur_y_next;

  blr_setup u_setup (
    .x_start (s1_x_start),
    .y_start (s1_y_start),
    .x_end   (s1_x_end),
    .y_end   (s1_y_end),
    .setup   (setup)
  );

  // Flow control: an item that produces a result waits for a free output slot.
  assign is_start  = (s1_op == OP_START);
  assign emits     = !is_start && busy;
  assign process   = s1_valid && (!emits || !out_valid || !out_stall);
  assign in_stall  = s1_valid && !process;
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // Current point: last flag and clipping against the screen size.
  assign is_last = ((steep ? cur_y : cur_x) == major_end);
  assign visible = !cur_x[COORD_BITS-1] && !cur_y[COORD_BITS-1] &&
                   (CMP_BITS'($unsigned(cur_x)) < CMP_BITS'(visible_cols)) &&
                   (CMP_BITS'($unsigned(cur_y)) < CMP_BITS'(visible_rows));

  // One Bresenham step: the error term folds both corrections into one sum.
  assign err_pos    = !error_term[ERR_BITS-1] && (error_term != '0);
  assign minor_step = err_pos ? (minor_neg ? -COORD_BITS'(1) : COORD_BITS'(1))
                              : '0;
  assign error_term_next = err_pos ?
      error_term + $signed(ERR_BITS'(twice_minor)) - $signed(ERR_BITS'(twice_major)) :
      error_term + $signed(ERR_BITS'(twice_minor));
  assign cur_x_next = steep ? cur_x + minor_step : cur_x + COORD_BITS'(1);
  assign cur_y_next = steep ? cur_y + COORD_BITS'(1) : cur_y + minor_step;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      visible_cols <= RESET_SCREEN_WIDTH;
      visible_rows <= RESET_SCREEN_HEIGHT;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SCREEN_WIDTH:  visible_cols <= cfg_data;
        REG_SCREEN_HEIGHT: visible_rows <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (process) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_op      <= op_t'(operation);
      s1_x_start <= x_start;
      s1_y_start <= y_start;
      s1_x_end   <= x_end;
      s1_y_end   <= y_end;
      s1_color   <= line_color;
    end
  end

  // Line state update: setup on a start, one step on each emitted point but the last.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (process) begin
      if (is_start) begin
        busy <= 1'b1;
      end else if (busy && is_last) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (process && is_start) begin
      steep       <= setup.steep;
      minor_neg   <= setup.minor_neg;
      cur_x       <= setup.cur_x;
      cur_y       <= setup.cur_y;
      major_end   <= setup.major_end;
      error_term  <= setup.error_term;
      twice_major <= setup.twice_major;
      twice_minor <= setup.twice_minor;
      held_color  <= s1_color;
    end else if (process && emits && !is_last) begin
      cur_x      <= cur_x_next;
      cur_y      <= cur_y_next;
      error_term <= error_term_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (process && emits) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (process && emits) begin
      pixel_x     <= cur_x;
      pixel_y     <= cur_y;
      pixel_color <= held_color;
      on_screen   <= visible;
      last        <= is_last;
    end
  end

  // A start always leaves a line in progress.
  assert property (@(posedge clk) disable iff (rst)
    (process && is_start) |=> busy)
    else $error("start item did not activate a line");

  // Emitting the final point ends the line.
  assert property (@(posedge clk) disable iff (rst)
    (process && emits && is_last) |=> !busy)
    else $error("line still active after its last point");

  // A new result appears only after a step was handled on an active line.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(process && emits))
    else $error("result produced without a step item");

  // The input side stalls only while a result-producing item and a stalled result both wait.
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && emits && out_valid && out_stall))
    else $error("input stalled without a blocked result");

endmodule

@@ tb/blr_line_checker.sv @@
// Checker for the line rasterizer: watches the configuration, input and result
// channels, predicts every point of the line and compares results in order.
// Depends on blr_pkg for widths, register indexes and operation codes.
module blr_line_checker (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_valid,
  input  logic                                  cfg_ready,
  input  logic [blr_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [blr_pkg::SIZE_BITS-1:0]         cfg_data,
  input  logic                                  in_valid,
  input  logic                                  in_stall,
  input  logic                                  operation,
  input  logic signed [blr_pkg::COORD_BITS-1:0] x_start,
  input  logic signed [blr_pkg::COORD_BITS-1:0] y_start,
  input  logic signed [blr_pkg::COORD_BITS-1:0] x_end,
  input  logic signed [blr_pkg::COORD_BITS-1:0] y_end,
  input  logic [blr_pkg::COLOR_BITS-1:0]        line_color,
  input  logic                                  out_valid,
  input  logic                                  out_stall,
  input  logic signed [blr_pkg::COORD_BITS-1:0] pixel_x,
  input  logic signed [blr_pkg::COORD_BITS-1:0] pixel_y,
  input  logic [blr_pkg::COLOR_BITS-1:0]        pixel_color,
  input  logic                                  on_screen,
  input  logic                                  last,
  output int                                    outstanding,
  output int                                    failures,
  output int                                    points_checked,
  output int                                    points_visible
);
  timeunit 1ns;
  timeprecision 1ps;
  import blr_pkg::*;

  // One emitted point, laid out like the result ports.
  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic [COLOR_BITS-1:0]        color;
    logic                         visible;
    logic                         final_point;
  } point_t;

  // Stepping state of the line being traced.
  typedef struct {
    bit                    busy;
    bit                    steep;
    bit                    minor_neg;
    int                    cur_x;
    int                    cur_y;
    int                    major_end;
    int                    err;
    int                    twice_major;
    int                    twice_minor;
    bit [COLOR_BITS-1:0]   color;
  } trace_t;

  trace_t              trace;
  bit [SIZE_BITS-1:0]  width_reg;
  bit [SIZE_BITS-1:0]  height_reg;
  point_t              points_due[$];
  int                  bad_count;
  int                  good_count;
  int                  shown_count;

  // Set up a new line: pick the major axis, order the endpoints, seed the error.
  function automatic void load_line(int xa, int ya, int xb, int yb,
                                    bit [COLOR_BITS-1:0] color);
    int t;
    int dx;
    int dy;
    dx = (xa > xb) ? xa - xb : xb - xa;
    dy = (ya > yb) ? ya - yb : yb - ya;
    trace.steep = !(dy < dx);
    if (trace.steep ? (ya > yb) : (xa > xb)) begin
      t = xa; xa = xb; xb = t;
      t = ya; ya = yb; yb = t;
    end
    if (trace.steep) begin
      trace.minor_neg   = xb < xa;
      trace.major_end   = yb;
      trace.twice_major = 2 * (yb - ya);
      trace.twice_minor = 2 * dx;
      trace.err         = 2 * dx - (yb - ya);
    end else begin
      trace.minor_neg   = yb < ya;
      trace.major_end   = xb;
      trace.twice_major = 2 * (xb - xa);
      trace.twice_minor = 2 * dy;
      trace.err         = 2 * dy - (xb - xa);
    end
    trace.cur_x = xa;
    trace.cur_y = ya;
    trace.color = color;
    trace.busy  = 1'b1;
  endfunction

  // Emit the current point and advance; returns 0 when no line is active.
  function automatic bit next_pixel(output point_t pt);
    bit at_end;
    int dir;
    pt = '0;
    if (!trace.busy) return 1'b0;
    at_end = ((trace.steep ? trace.cur_y : trace.cur_x) == trace.major_end);
    pt.x           = COORD_BITS'(trace.cur_x);
    pt.y           = COORD_BITS'(trace.cur_y);
    pt.color       = trace.color;
    pt.visible     = trace.cur_x >= 0 && trace.cur_x < int'(width_reg) &&
                     trace.cur_y >= 0 && trace.cur_y < int'(height_reg);
    pt.final_point = at_end;
    if (at_end) begin
      trace.busy = 1'b0;
    end else begin
      dir = trace.minor_neg ? -1 : 1;
      if (trace.err > 0) begin
        if (trace.steep) trace.cur_x += dir;
        else trace.cur_y += dir;
        trace.err -= trace.twice_major;
      end
      trace.err += trace.twice_minor;
      if (trace.steep) trace.cur_y += 1;
      else trace.cur_x += 1;
    end
    return 1'b1;
  endfunction

  // Track the channels at every edge; outputs to the top change by NBA only.
  always @(posedge clk) begin
    point_t fresh;
    point_t got;
    point_t want;
    if (rst) begin
      trace      = '{default: 0};
      width_reg  = RESET_SCREEN_WIDTH;
      height_reg = RESET_SCREEN_HEIGHT;
      points_due.delete();
    end else begin
      // Screen size writes.
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_SCREEN_WIDTH) width_reg = cfg_data;
        else if (cfg_index == REG_SCREEN_HEIGHT) height_reg = cfg_data;
      end
      // Accepted input item.
      if (in_valid && !in_stall) begin
        if (operation == OP_START) begin
          load_line(int'(x_start), int'(y_start), int'(x_end), int'(y_end), line_color);
        end else if (next_pixel(fresh)) begin
          points_due.push_back(fresh);
        end
      end
      // Accepted result item.
      if (out_valid && !out_stall) begin
        got = '{pixel_x, pixel_y, pixel_color, on_screen, last};
        if (points_due.size() == 0) begin
          bad_count++;
          if (shown_count < 10) begin
            shown_count++;
            $display("[%0t] unexpected point x=%0d y=%0d color=%h on=%b last=%b",
                     $realtime, got.x, got.y, got.color, got.visible, got.final_point);
          end
        end else begin
          want = points_due.pop_front();
          if (got.x !== want.x || got.y !== want.y || got.color !== want.color ||
              got.visible !== want.visible || got.final_point !== want.final_point) begin
            bad_count++;
            if (shown_count < 10) begin
              shown_count++;
              $display("[%0t] point mismatch: expected x=%0d y=%0d color=%h on=%b last=%b",
                       $realtime, want.x, want.y, want.color, want.visible,
                       want.final_point);
              $display("[%0t]                 actual   x=%0d y=%0d color=%h on=%b last=%b",
                       $realtime, got.x, got.y, got.color, got.visible, got.final_point);
            end
          end else begin
            good_count++;
            if (want.visible) points_visible <= points_visible + 1;
          end
        end
      end
    end
    outstanding    <= points_due.size();
    failures       <= bad_count;
    points_checked <= good_count;
  end

  initial begin
    bad_count      = 0;
    good_count     = 0;
    shown_count    = 0;
    outstanding    = 0;
    failures       = 0;
    points_checked = 0;
    points_visible = 0;
  end

endmodule

@@ tb/testbench.sv @@
// Top of the line rasterizer testbench: clock, reset, stimulus and verdict.
// Instantiates bresenham_line_rasterizer and blr_line_checker; uses blr_pkg.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import blr_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_HOLD   = 200;
  localparam int PHASE_ITEMS = 100;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [CFG_INDEX_BITS-1:0]    cfg_index = REG_SCREEN_WIDTH;
  logic [SIZE_BITS-1:0]         cfg_data = '0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic                         operation = OP_STEP;
  logic signed [COORD_BITS-1:0] x_start = '0;
  logic signed [COORD_BITS-1:0] y_start = '0;
  logic signed [COORD_BITS-1:0] x_end = '0;
  logic signed [COORD_BITS-1:0] y_end = '0;
  logic [COLOR_BITS-1:0]        line_color = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic signed [COORD_BITS-1:0] pixel_x;
  logic signed [COORD_BITS-1:0] pixel_y;
  logic [COLOR_BITS-1:0]        pixel_color;
  logic                         on_screen;
  logic                         last;

  int outstanding;
  int failures;
  int points_checked;
  int points_visible;

  int idle_pct    = 0;
  int stall_pct   = 0;
  int holds_asked = 0;
  int holds_done  = 0;
  int hold_left   = 0;
  int items_sent  = 0;
  int lines_sent  = 0;
  int cycles      = 0;
  int screen_w    = RESET_SCREEN_WIDTH;
  int screen_h    = RESET_SCREEN_HEIGHT;

  bresenham_line_rasterizer u_top (.*);

  blr_line_checker u_checker (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Cycle budget for the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  // Result side: random stalls, plus a long hold-off whenever one is requested.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (holds_done != holds_asked) begin
      out_stall  <= 1'b1;
      hold_left  <= LONG_HOLD - 1;
      holds_done <= holds_done + 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  function automatic int fit_coord(int v);
    if (v > 1023) return 1023;
    if (v < -1024) return -1024;
    return v;
  endfunction

  // Offer one item after a random gap and wait until the block takes it.
  task automatic send_item(input op_t op, input int xs, input int ys, input int xe,
                           input int ye, input int color);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    operation  <= op;
    x_start    <= COORD_BITS'(xs);
    y_start    <= COORD_BITS'(ys);
    x_end      <= COORD_BITS'(xe);
    y_end      <= COORD_BITS'(ye);
    line_color <= COLOR_BITS'(color);
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (op == OP_START) lines_sent++;
  endtask

  // Step items carry junk in the fields that only a start uses.
  task automatic step_n(input int n);
    repeat (n) begin
      send_item(OP_STEP, int'($urandom_range(2047)) - 1024,
                int'($urandom_range(2047)) - 1024, int'($urandom_range(2047)) - 1024,
                int'($urandom_range(2047)) - 1024, $urandom_range(16'hFFFF));
    end
  endtask

  // Let every expected point arrive and the pipeline empty out. The first
  // edge lets the checker's count catch up with the last accepted item.
  task automatic drain();
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write both screen size registers back to back.
  task automatic set_screen(input int w, input int h);
    cfg_valid <= 1'b1;
    cfg_index <= REG_SCREEN_WIDTH;
    cfg_data  <= SIZE_BITS'(w);
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= REG_SCREEN_HEIGHT;
    cfg_data  <= SIZE_BITS'(h);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    screen_w = w;
    screen_h = h;
  endtask

  // A start near the screen (sometimes anywhere) followed by its steps;
  // some lines are cut short by the next start, some get extra idle steps.
  task automatic random_line();
    int xs, ys, xe, ye, points, n, r;
    if ($urandom_range(9) == 0) begin
      xs = int'($urandom_range(2047)) - 1024;
      ys = int'($urandom_range(2047)) - 1024;
      xe = int'($urandom_range(2047)) - 1024;
      ye = int'($urandom_range(2047)) - 1024;
    end else begin
      xs = fit_coord(int'($urandom_range(screen_w + 16)) - 8);
      ys = fit_coord(int'($urandom_range(screen_h + 16)) - 8);
      xe = fit_coord(xs + int'($urandom_range(40)) - 20);
      ye = fit_coord(ys + int'($urandom_range(40)) - 20);
    end
    points = (xe > xs) ? xe - xs : xs - xe;
    if (((ye > ys) ? ye - ys : ys - ye) > points) points = (ye > ys) ? ye - ys : ys - ye;
    points += 1;
    r = $urandom_range(9);
    if (r < 7) n = points;
    else if (r == 7) n = $urandom_range(points - 1);
    else n = points + $urandom_range(3, 1);
    if (n > 48) n = 48;
    send_item(OP_START, xs, ys, xe, ye, $urandom_range(16'hFFFF));
    step_n(n);
  endtask

  initial begin
    int goal;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed lines at the reset screen size.
    step_n(1);                                          // step with no line active
    send_item(OP_START, -1024, -1024, 1023, 1023, 16'h0000);
    step_n(2);
    send_item(OP_START, 1023, 1023, -1024, -1024, 16'hFFFF); // replaces, swapped
    step_n(1);
    send_item(OP_START, 5, 5, 5, 5, 16'hA5A5);             // single point
    step_n(2);
    send_item(OP_START, 3, 7, 0, 7, 16'h5A5A);             // horizontal, reversed
    step_n(4);
    send_item(OP_START, 2, 0, 0, 3, 16'h0F0F);             // steep, minor axis falling
    step_n(4);
    send_item(OP_START, 125, 94, 129, 96, 16'hF0F0);       // crosses the screen corner
    step_n(5);
    in_valid <= 1'b0;
    drain();

    // Random phases, each at its own screen size and one of four idling mixes.
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: set_screen(1023, 1023);
        1: set_screen(0, 0);
        2: set_screen(1, 1023);
        3: set_screen(1023, 1);
        default: set_screen($urandom_range(1023, 1), $urandom_range(1023, 1));
      endcase
      idle_pct  = (phase == 1) ? 80 : (phase == 3) ? 18 : 0;
      stall_pct <= (phase == 2) ? 80 : (phase == 3) ? 18 : 0;
      @(posedge clk);
      if (phase == 4) begin
        // Long receiver hold-off while steps keep coming, to back up the block.
        send_item(OP_START, -20, 3, 280, 40, $urandom_range(16'hFFFF));
        holds_asked <= holds_asked + 1;
        step_n(301);
      end
      goal = items_sent + PHASE_ITEMS;
      while (items_sent < goal) begin
        if ($urandom_range(19) == 0) begin
          send_item(op_t'($urandom_range(1)), int'($urandom_range(2047)) - 1024,
                    int'($urandom_range(2047)) - 1024, int'($urandom_range(2047)) - 1024,
                    int'($urandom_range(2047)) - 1024, $urandom_range(16'hFFFF));
        end else begin
          random_line();
        end
      end
      in_valid <= 1'b0;
      drain();
    end

    repeat (20) @(posedge clk);
    $display("Sent %0d items (%0d lines) over six screen sizes and four idling mixes,",
             items_sent, lines_sent);
    $display("with %0d long output hold-off; %0d points matched, %0d of them visible.",
             holds_done, points_checked, points_visible);
    if (failures == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
